@@ rtl/core/mse_pkg.sv @@
// mse_pkg: operation codes and fixed constants of the mips subset execute block
// no dependencies
package mse_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int LINE_BITS = 12;

  localparam logic [REG_BITS-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_BITS-1:0] REG_AT = 5'd1;

  typedef enum logic [4:0] {
    K_ADD  = 5'd0,
    K_SUB  = 5'd1,
    K_MUL  = 5'd2,
    K_AND  = 5'd3,
    K_OR   = 5'd4,
    K_NOR  = 5'd5,
    K_SLT  = 5'd6,
    K_ADDI = 5'd7,
    K_ANDI = 5'd8,
    K_ORI  = 5'd9,
    K_SLTI = 5'd10,
    K_LW   = 5'd11,
    K_SW   = 5'd12,
    K_BEQ  = 5'd13,
    K_BNE  = 5'd14,
    K_J    = 5'd15,
    K_LA   = 5'd16
  } kind_t;

endpackage

@@ rtl/core/mse_instr_if.sv @@
// mse_instr_if: instruction channel, valid/ready with decoded fields
// no dependencies
interface mse_instr_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  kind;
  logic        [4:0]  dest_reg;
  logic        [4:0]  src_reg;
  logic        [4:0]  src2_reg;
  logic signed [31:0] immediate;
  logic        [11:0] target_line;

  modport source (output valid, kind, dest_reg, src_reg, src2_reg, immediate, target_line,
                  input ready);
  modport sink (input valid, kind, dest_reg, src_reg, src2_reg, immediate, target_line,
                output ready);
endinterface

@@ rtl/core/mse_result_if.sv @@
// mse_result_if: result channel, valid/ready with one result beat
// no dependencies
interface mse_result_if #(
  parameter int PC_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [PC_BITS-1:0]   next_pc;
  logic                 write_done;
  logic [4:0]           written_reg;
  logic signed [31:0]   written_value;
  logic                 branch_taken;
  logic                 mem_fault;

  modport source (output valid, next_pc, write_done, written_reg, written_value, branch_taken,
                  mem_fault, input ready);
  modport sink (input valid, next_pc, write_done, written_reg, written_value, branch_taken,
                mem_fault, output ready);
endinterface

@@ rtl/core/mse_cfg_if.sv @@
// mse_cfg_if: configuration write channel carrying the start line
// no dependencies
interface mse_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/mse_ram.sv @@
// mse_ram: generic single write, single read ram with registered read data
// no dependencies
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/mips_subset_execute.sv @@
// mips_subset_execute: top level, execute stage, memory stage and result register
// depends on mse_pkg, the channel interfaces and mse_ram
// beats pass execute, memory and result registers; one per cycle while result.ready is high
// register file and data memory reads are registered, operands forwarded from later stages
// reset: synchronous, clears control state; then a clearing pass over max(MEM_WORDS, 32) words
// zeroes data memory and register file with instr.ready low; cfg beats are taken at any time
module mips_subset_execute #(
  parameter int MEM_WORDS = 1024,
  parameter int PC_BITS = 12
) (
  input logic         clk,
  input logic         rst,
  mse_instr_if.sink   instr,
  mse_result_if.source result,
  mse_cfg_if.sink     cfg
);
  import mse_pkg::*;

  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int CLR_WORDS = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
  localparam int CLR_BITS = $clog2(CLR_WORDS);

  // clearing pass
  logic                clearing;
  logic [CLR_BITS-1:0] clr_idx;

  // execute stage
  logic                 s1_v;
  kind_t                s1_kind;
  logic [REG_BITS-1:0]  s1_rd, s1_rs, s1_rt;
  logic [DATA_BITS-1:0] s1_imm;
  logic [LINE_BITS-1:0] s1_tgt;
  logic [PC_BITS-1:0]   pc;

  // memory stage
  logic                 s2_v, s2_wr, s2_load, s2_taken, s2_fault;
  logic [REG_BITS-1:0]  s2_rd;
  logic [DATA_BITS-1:0] s2_val;
  logic [PC_BITS-1:0]   s2_npc;

  // result register
  logic                 out_v, out_wr, out_taken, out_fault;
  logic [REG_BITS-1:0]  out_rd;
  logic [DATA_BITS-1:0] out_val;
  logic [PC_BITS-1:0]   out_npc;

  // last register file write
  logic                 lw_v;
  logic [REG_BITS-1:0]  lw_reg;
  logic [DATA_BITS-1:0] lw_val;

  logic in_acc, s1_adv, s2_free, out_load, s1_free;
  logic [DATA_BITS-1:0] rf_a_rdata, rf_b_rdata, rf_d_rdata, dm_rdata, s2_wval;
  logic [DATA_BITS-1:0] op_a, op_b, op_d;
  logic                 rf_we;
  logic [REG_BITS-1:0]  rf_waddr;
  logic [DATA_BITS-1:0] rf_wdata;
  logic [REG_BITS-1:0]  ra_a, ra_b, ra_d;

  logic                 ex_wr, ex_taken, ex_fault, ex_load, ex_store;
  logic [DATA_BITS-1:0] ex_val;
  logic [PC_BITS-1:0]   ex_npc;
  logic                 rtype_ok;
  logic [33:0]          imm_adj, imm_quarter, word_sum;
  logic                 idx_bad;
  logic [MEM_AW-1:0]    dm_idx;
  logic                 dm_we, dm_re;
  logic [MEM_AW-1:0]    dm_waddr;
  logic [DATA_BITS-1:0] dm_wdata;
  logic [31:0]          tgt_ext;

  // handshakes
  assign out_load = s2_v && (!out_v || result.ready);
  assign s2_free  = !s2_v || out_load;
  assign s1_adv   = s1_v && s2_free;
  assign s1_free  = !s1_v || s1_adv;
  assign instr.ready = s1_free && !clearing;
  assign in_acc   = instr.valid && instr.ready;
  assign cfg.ready = 1'b1;

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == CLR_BITS'(CLR_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + CLR_BITS'(1);
    end
  end

  // register file, one copy per read port
  assign ra_a = in_acc ? instr.src_reg  : s1_rs;
  assign ra_b = in_acc ? instr.src2_reg : s1_rt;
  assign ra_d = in_acc ? instr.dest_reg : s1_rd;

  assign s2_wval  = s2_load ? dm_rdata : s2_val;
  assign rf_we    = clearing || (out_load && s2_wr);
  assign rf_waddr = clearing ? clr_idx[REG_BITS-1:0] : s2_rd;
  assign rf_wdata = clearing ? '0 : s2_wval;

  mse_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(1'b1), .raddr(ra_a), .rdata(rf_a_rdata)
  );
  mse_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(1'b1), .raddr(ra_b), .rdata(rf_b_rdata)
  );
  mse_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_REGS)) u_rf_d (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(1'b1), .raddr(ra_d), .rdata(rf_d_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_v <= 1'b0;
    end else begin
      lw_v <= out_load && s2_wr;
    end
    lw_reg <= s2_rd;
    lw_val <= s2_wval;
  end

  // operand forwarding: pending write in memory stage, then write of the last edge
  assign op_a = (s2_v && s2_wr && s2_rd == s1_rs) ? s2_wval :
                (lw_v && lw_reg == s1_rs) ? lw_val : rf_a_rdata;
  assign op_b = (s2_v && s2_wr && s2_rd == s1_rt) ? s2_wval :
                (lw_v && lw_reg == s1_rt) ? lw_val : rf_b_rdata;
  assign op_d = (s2_v && s2_wr && s2_rd == s1_rd) ? s2_wval :
                (lw_v && lw_reg == s1_rd) ? lw_val : rf_d_rdata;

  // word index, byte offset divided by four toward zero
  assign imm_adj     = {{2{s1_imm[31]}}, s1_imm} + {32'd0, s1_imm[31], s1_imm[31]};
  assign imm_quarter = 34'($signed(imm_adj) >>> 2);
  assign word_sum    = {{2{op_a[31]}}, op_a} + imm_quarter;
  assign idx_bad     = word_sum[33] || (word_sum >= 34'(MEM_WORDS));
  assign dm_idx      = word_sum[MEM_AW-1:0];

  assign rtype_ok = (s1_rd != REG_ZERO) && (s1_rd != REG_AT) && (s1_rs != REG_AT)
                    && (s1_rt != REG_AT);
  assign tgt_ext  = {20'd0, s1_tgt};

  always_comb begin
    ex_val   = '0;
    ex_wr    = 1'b0;
    ex_taken = 1'b0;
    ex_fault = 1'b0;
    ex_load  = 1'b0;
    ex_store = 1'b0;
    ex_npc   = pc + PC_BITS'(1);
    unique case (s1_kind)
      K_ADD: begin ex_val = op_a + op_b; ex_wr = rtype_ok; end
      K_SUB: begin ex_val = op_a - op_b; ex_wr = rtype_ok; end
      K_MUL: begin ex_val = op_a * op_b; ex_wr = rtype_ok; end
      K_AND: begin ex_val = op_a & op_b; ex_wr = rtype_ok; end
      K_OR: begin ex_val = op_a | op_b; ex_wr = rtype_ok; end
      K_NOR: begin ex_val = ~(op_a | op_b); ex_wr = rtype_ok; end
      K_SLT: begin
        ex_val = {31'd0, $signed(op_a) < $signed(op_b)};
        ex_wr  = rtype_ok;
      end
      K_ADDI: begin ex_val = op_a + s1_imm; ex_wr = s1_rd != REG_ZERO; end
      K_ANDI: begin ex_val = op_a & s1_imm; ex_wr = s1_rd != REG_ZERO; end
      K_ORI: begin ex_val = op_a | s1_imm; ex_wr = s1_rd != REG_ZERO; end
      K_SLTI: begin
        ex_val = {31'd0, $signed(op_a) < $signed(s1_imm)};
        ex_wr  = s1_rd != REG_ZERO;
      end
      K_LW: begin
        ex_fault = idx_bad;
        ex_load  = !idx_bad;
        ex_wr    = !idx_bad && (s1_rd != REG_ZERO);
      end
      K_SW: begin
        ex_fault = idx_bad;
        ex_store = !idx_bad;
      end
      K_BEQ: begin
        if (op_d == op_a) begin
          ex_taken = 1'b1;
          ex_npc   = PC_BITS'(tgt_ext + 32'd1);
        end
      end
      K_BNE: begin
        if (op_d != op_a) begin
          ex_taken = 1'b1;
          ex_npc   = PC_BITS'(tgt_ext + 32'd1);
        end
      end
      K_J: begin
        ex_taken = 1'b1;
        ex_npc   = PC_BITS'(tgt_ext);
      end
      K_LA: begin ex_val = tgt_ext; ex_wr = s1_rd != REG_ZERO; end
      default: ;
    endcase
    if (!ex_wr) begin
      ex_val = '0;
    end
  end

  // data memory
  assign dm_we    = clearing || (s1_adv && ex_store);
  assign dm_waddr = clearing ? clr_idx[MEM_AW-1:0] : dm_idx;
  assign dm_wdata = clearing ? '0 : op_d;
  assign dm_re    = s1_adv && ex_load;

  mse_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_re), .raddr(dm_idx), .rdata(dm_rdata)
  );

  // execute stage register and program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      pc   <= '0;
    end else begin
      if (s1_free) begin
        s1_v <= in_acc;
      end
      if (cfg.valid && cfg.ready) begin
        pc <= PC_BITS'({20'd0, cfg.data});
      end else if (s1_adv) begin
        pc <= ex_npc;
      end
    end
    if (in_acc) begin
      s1_kind <= kind_t'(instr.kind);
      s1_rd   <= instr.dest_reg;
      s1_rs   <= instr.src_reg;
      s1_rt   <= instr.src2_reg;
      s1_imm  <= instr.immediate;
      s1_tgt  <= instr.target_line;
    end
  end

  // memory stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_adv;
    end
    if (s1_adv) begin
      s2_wr    <= ex_wr;
      s2_load  <= ex_load;
      s2_taken <= ex_taken;
      s2_fault <= ex_fault;
      s2_rd    <= ex_wr ? s1_rd : REG_ZERO;
      s2_val   <= ex_val;
      s2_npc   <= ex_npc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
    if (out_load) begin
      out_wr    <= s2_wr;
      out_rd    <= s2_rd;
      out_val   <= s2_wr ? s2_wval : '0;
      out_taken <= s2_taken;
      out_fault <= s2_fault;
      out_npc   <= s2_npc;
    end
  end

  assign result.valid         = out_v;
  assign result.next_pc       = out_npc;
  assign result.write_done    = out_wr;
  assign result.written_reg   = out_rd;
  assign result.written_value = out_val;
  assign result.branch_taken  = out_taken;
  assign result.mem_fault     = out_fault;

`ifndef SYNTHESIS
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !instr.ready)
    else $error("instruction taken during clearing pass");

  a_reg_zero_kept: assert property (@(posedge clk) disable iff (rst)
    (rf_we && !clearing) |-> (rf_waddr != REG_ZERO))
    else $error("register zero written");

  a_dmem_write_source: assert property (@(posedge clk) disable iff (rst)
    (dm_we && !clearing) |-> (s1_adv && s1_kind == K_SW && !idx_bad))
    else $error("data memory written outside a store");

  a_pc_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !ex_taken && !(cfg.valid && cfg.ready)) |=> (pc == $past(pc) + PC_BITS'(1)))
    else $error("program counter did not advance by one");

  a_no_write_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_wr) |-> (out_rd == REG_ZERO && out_val == '0))
    else $error("result write fields not cleared");
`endif

endmodule

@@ tb/mse_exec_checker.sv @@
`timescale 1ns / 100ps
// mse_exec_checker: watches the instruction, result and start-line channels of the execute block,
// predicts every result beat from its own register file, data memory and pc, and compares.
// depends on mse_pkg and the three channel interfaces
module mse_exec_checker #(
  parameter int MEM_WORDS = 1024,
  parameter int PC_BITS = 12
) (
  input  logic  clk,
  input  logic  rst,
  mse_instr_if  instr,
  mse_result_if result,
  mse_cfg_if    cfg,
  output int    fail_count,
  output int    pending,
  output int    beats_checked
);
  import mse_pkg::*;

  typedef struct packed {
    logic [PC_BITS-1:0] next_pc;
    logic               write_done;
    logic [4:0]         written_reg;
    logic [31:0]        written_value;
    logic               branch_taken;
    logic               mem_fault;
  } exec_result_t;

  logic [31:0]          regs [NUM_REGS];
  logic [31:0]          dmem [MEM_WORDS];
  logic [PC_BITS-1:0]   pc;
  exec_result_t         pending_results [$];

  task automatic execute_instr(input logic [4:0] kind, input logic [4:0] rd, input logic [4:0] rs,
                               input logic [4:0] rt, input logic [31:0] imm,
                               input logic [11:0] tgt, output exec_result_t res);
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        d;
    logic [31:0]        val;
    logic [PC_BITS-1:0] npc;
    logic               wr;
    logic               taken;
    logic               fault;
    longint             idx;
    a = regs[rs];
    b = regs[rt];
    d = regs[rd];
    val = '0;
    wr = 1'b0;
    taken = 1'b0;
    fault = 1'b0;
    npc = pc + PC_BITS'(1);
    case (kind)
      K_ADD:  val = a + b;
      K_SUB:  val = a - b;
      K_MUL:  val = a * b;
      K_AND:  val = a & b;
      K_OR:   val = a | b;
      K_NOR:  val = ~(a | b);
      K_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      K_ADDI: val = a + imm;
      K_ANDI: val = a & imm;
      K_ORI:  val = a | imm;
      K_SLTI: val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
      K_LW, K_SW: begin
        idx = longint'($signed(a)) + longint'($signed(imm)) / 4;
        if (idx < 0 || idx >= longint'(MEM_WORDS)) begin
          fault = 1'b1;
        end else if (kind == K_LW) begin
          val = dmem[int'(idx)];
          wr = rd != REG_ZERO;
        end else begin
          dmem[int'(idx)] = d;
        end
      end
      K_BEQ, K_BNE: begin
        if ((kind == K_BEQ) == (d == a)) begin
          taken = 1'b1;
          npc = PC_BITS'(32'(tgt) + 32'd1);
        end
      end
      K_J: begin
        taken = 1'b1;
        npc = PC_BITS'(tgt);
      end
      K_LA: begin
        val = 32'(tgt);
        wr = rd != REG_ZERO;
      end
      default: ;
    endcase
    // r-type guard on $zero and $at, immediate-type guard on $zero
    if (kind <= K_SLT)
      wr = rd != REG_ZERO && rd != REG_AT && rs != REG_AT && rt != REG_AT;
    else if (kind >= K_ADDI && kind <= K_SLTI)
      wr = rd != REG_ZERO;
    if (wr)
      regs[rd] = val;
    else
      val = '0;
    pc = npc;
    res = '{next_pc: npc, write_done: wr, written_reg: wr ? rd : 5'd0, written_value: val,
            branch_taken: taken, mem_fault: fault};
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    exec_result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
      pc = '0;
      pending_results.delete();
      fail_count = 0;
      beats_checked = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{next_pc: result.next_pc, write_done: result.write_done,
                written_reg: result.written_reg, written_value: result.written_value,
                branch_taken: result.branch_taken, mem_fault: result.mem_fault};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat with nothing outstanding: pc=%0d wd=%0b reg=%0d val=%h",
                     got.next_pc, got.write_done, got.written_reg, got.written_value);
        end else begin
          want = pending_results.pop_front();
          beats_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("beat %0d mismatch: expected pc=%0d wd=%0b reg=%0d val=%h br=%0b flt=%0b",
                       beats_checked, want.next_pc, want.write_done, want.written_reg,
                       want.written_value, want.branch_taken, want.mem_fault,
                       ", got pc=%0d wd=%0b reg=%0d val=%h br=%0b flt=%0b",
                       got.next_pc, got.write_done, got.written_reg,
                       got.written_value, got.branch_taken, got.mem_fault);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        pc = PC_BITS'(cfg.data);
      end
      if (instr.valid && instr.ready) begin
        execute_instr(instr.kind, instr.dest_reg, instr.src_reg, instr.src2_reg,
                      instr.immediate, instr.target_line, want);
        pending_results = {pending_results, want};
      end
    end
    pending = pending_results.size();
  end

endmodule

@@ tb/tb_mips_subset_execute.sv @@
`timescale 1ns / 100ps
// tb_mips_subset_execute: drives directed and random instruction streams under several start
// lines with random idling on both channels; depends on mse_pkg, the interfaces, the block and
// mse_exec_checker, which predicts and compares every result beat
module tb_mips_subset_execute;
  import mse_pkg::*;

  localparam int MEM_WORDS = 1024;
  localparam int PC_BITS = 12;
  localparam int ITEMS_PER_PHASE = 285;
  localparam int NUM_PHASES = 6;
  localparam int CYCLE_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_idle = 1'b0;
  int   cycles = 0;
  int   sent = 0;
  int   fail_count;
  int   pending;
  int   beats_checked;
  logic [11:0] phase_start [NUM_PHASES];

  mse_instr_if instr ();
  mse_result_if #(.PC_BITS(PC_BITS)) result ();
  mse_cfg_if cfg ();

  mips_subset_execute #(.MEM_WORDS(MEM_WORDS), .PC_BITS(PC_BITS)) uut (
    .clk(clk), .rst(rst), .instr(instr), .result(result), .cfg(cfg)
  );

  mse_exec_checker #(.MEM_WORDS(MEM_WORDS), .PC_BITS(PC_BITS)) exec_check (
    .clk(clk), .rst(rst), .instr(instr), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    result.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);

  task automatic send_instr(input logic [4:0] k, input logic [4:0] rd, input logic [4:0] rs,
                            input logic [4:0] rt, input logic [31:0] imm, input logic [11:0] tgt);
    while (!no_idle && $urandom_range(99) < 6) begin
      instr.valid <= 1'b0;
      @(negedge clk);
    end
    instr.valid <= 1'b1;
    instr.kind <= k;
    instr.dest_reg <= rd;
    instr.src_reg <= rs;
    instr.src2_reg <= rt;
    instr.immediate <= imm;
    instr.target_line <= tgt;
    do @(posedge clk); while (!instr.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_start(input logic [11:0] line);
    cfg.valid <= 1'b1;
    cfg.data <= line;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    instr.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4, 5: return 32'($urandom_range(64)) - 32'd32;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_instr();
    logic [4:0]  k;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm;
    int          roll;
    roll = $urandom_range(99);
    rd = 5'($urandom_range(31));
    rs = 5'($urandom_range(31));
    rt = 5'($urandom_range(31));
    imm = pick_imm();
    if (roll < 4)
      k = 5'($urandom_range(31, 17));
    else if (roll < 16)
      k = K_LA;
    else if (roll < 36) begin
      k = ($urandom_range(1) == 0) ? K_LW : K_SW;
      // mostly word indexes near or inside memory
      if ($urandom_range(1) == 0) begin
        rs = REG_ZERO;
        imm = 32'($urandom_range(4 * MEM_WORDS + 64)) - 32'd32;
      end else if ($urandom_range(3) != 0) begin
        imm = 32'($urandom_range(255)) - 32'd128;
      end
    end else if (roll < 48) begin
      k = 5'($urandom_range(K_J, K_BEQ));
      if ($urandom_range(9) < 4) rs = rd;
    end else
      k = 5'($urandom_range(K_SLTI, K_ADD));
    send_instr(k, rd, rs, rt, imm, 12'($urandom_range(4095)));
  endtask

  initial begin
    instr.valid = 1'b0;
    instr.kind = '0;
    instr.dest_reg = '0;
    instr.src_reg = '0;
    instr.src2_reg = '0;
    instr.immediate = '0;
    instr.target_line = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    phase_start[0] = 12'd4095;
    phase_start[1] = 12'd0;
    phase_start[2] = 12'($urandom_range(4095));
    phase_start[3] = 12'd2048;
    phase_start[4] = 12'd1;
    phase_start[5] = 12'($urandom_range(4095));
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_start(phase_start[0]);
    send_instr(K_LA,   5'd2,  5'd0, 5'd0, 32'd0, 12'd4095);
    send_instr(K_ADDI, 5'd3,  5'd0, 5'd0, 32'h8000_0000, 12'd0);
    send_instr(K_ADDI, 5'd4,  5'd0, 5'd0, 32'h7fff_ffff, 12'd0);
    send_instr(K_ADD,  5'd5,  5'd3, 5'd4, 32'd0, 12'd0);
    send_instr(K_SUB,  5'd6,  5'd3, 5'd4, 32'd0, 12'd0);
    send_instr(K_MUL,  5'd7,  5'd4, 5'd4, 32'd0, 12'd0);
    send_instr(K_AND,  5'd8,  5'd2, 5'd4, 32'd0, 12'd0);
    send_instr(K_OR,   5'd9,  5'd3, 5'd2, 32'd0, 12'd0);
    send_instr(K_NOR,  5'd10, 5'd3, 5'd2, 32'd0, 12'd0);
    send_instr(K_SLT,  5'd11, 5'd3, 5'd4, 32'd0, 12'd0);
    send_instr(K_ADD,  REG_AT, 5'd4, 5'd4, 32'd0, 12'd0);
    send_instr(K_SUB,  5'd12, REG_AT, 5'd4, 32'd0, 12'd0);
    send_instr(K_ANDI, 5'd13, 5'd4, 5'd0, 32'hffff_ffff, 12'd0);
    send_instr(K_ORI,  5'd14, 5'd0, 5'd0, 32'h8000_0000, 12'd0);
    send_instr(K_SLTI, 5'd15, 5'd3, 5'd0, 32'd0, 12'd0);
    // top word, then truncation of a negative offset to word zero
    send_instr(K_SW,   5'd4,  5'd0, 5'd0, 32'd4092, 12'd0);
    send_instr(K_LW,   5'd16, 5'd0, 5'd0, 32'd4092, 12'd0);
    send_instr(K_LW,   5'd17, 5'd0, 5'd0, 32'hffff_fffd, 12'd0);
    send_instr(K_SW,   5'd4,  5'd0, 5'd0, 32'd4096, 12'd0);
    send_instr(K_LW,   5'd18, 5'd3, 5'd0, 32'd0, 12'd0);
    send_instr(K_BEQ,  5'd0,  5'd0, 5'd0, 32'd0, 12'd4095);
    send_instr(K_BNE,  5'd3,  5'd3, 5'd0, 32'd0, 12'd7);
    send_instr(K_J,    5'd0,  5'd0, 5'd0, 32'd0, 12'd4095);
    send_instr(5'd31,  5'd19, 5'd4, 5'd4, 32'd5, 12'd9);
    send_instr(K_ADDI, REG_ZERO, 5'd4, 5'd0, 32'd1, 12'd0);
    drain();

    for (int p = 1; p < NUM_PHASES; p++) begin
      write_start(phase_start[p]);
      no_idle = (p == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_instr();
      drain();
      no_idle = 1'b0;
    end
    repeat (10) @(negedge clk);

    $display("%0d instructions over %0d start lines, %0d result beats compared, %0d failures",
             sent, NUM_PHASES, beats_checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mse_pkg.sv
rtl/core/mse_instr_if.sv
rtl/core/mse_result_if.sv
rtl/core/mse_cfg_if.sv
rtl/core/mse_ram.sv
rtl/core/mips_subset_execute.sv
tb/mse_exec_checker.sv
tb/tb_mips_subset_execute.sv
